@@ rtl/core/trsm_pkg.sv @@
// Shared types, codes and constants of the TCP receive state machine.
package trsm_pkg;

	// TCP flag bits as they appear in the flag byte.
	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	// Reset values of the configuration registers.
	localparam logic [3:0]  MAX_DUP_ACKS_RST = 4'd5;
	localparam logic [31:0] LISTEN_ISN_RST   = 32'd1000;

	// Depth of the queue between front and back.
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);

	// Packed widths of the stream words.
	localparam int IN_W  = 64;
	localparam int OUT_W = 88;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_START_STATE    = 2'd0,
		CFG_OPEN_DIRECTION = 2'd1,
		CFG_MAX_DUP_ACKS   = 2'd2,
		CFG_LISTEN_ISN     = 2'd3
	} cfg_index_t;

	// Connection states.
	typedef enum logic [3:0] {
		ST_CLOSED    = 4'd0,
		ST_LISTEN    = 4'd1,
		ST_SYNSENT   = 4'd2,
		ST_SYNRCVD   = 4'd3,
		ST_ESTAB     = 4'd4,
		ST_CLOSEWAIT = 4'd5,
		ST_LASTACK   = 4'd6,
		ST_FINWAIT1  = 4'd7,
		ST_FINWAIT2  = 4'd8,
		ST_CLOSING   = 4'd9,
		ST_TIMEWAIT  = 4'd10
	} conn_state_t;

	// Action to transmit.
	typedef enum logic [2:0] {
		TX_NONE   = 3'd0,
		TX_RST    = 3'd1,
		TX_SYNACK = 3'd2,
		TX_ACK    = 3'd3,
		TX_DACK   = 3'd4
	} tx_action_t;

	// Connect error codes.
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FIN   = 2'd1,
		ERR_RST   = 2'd2,
		ERR_UNEXP = 2'd3
	} err_code_t;

	// A segment after classification by the front.
	typedef struct packed {
		logic        f_syn;
		logic        f_synack;
		logic        f_finack;
		logic        f_rstack;
		logic        f_ack;
		logic        f_fin;
		logic        rst_bit;
		logic        fin_bit;
		logic        len_nz;
		logic        accepted;
		logic        owner;
		tx_action_t  dack;
		logic [31:0] seq;
		logic [31:0] seq_len;
		logic [31:0] seq_len1;
	} seg_dec_t;

	// One result word.
	typedef struct packed {
		logic [3:0]  dup_count;
		logic        release_owner;
		logic        setup_done;
		logic        connected;
		err_code_t   error_code;
		logic        deliver;
		tx_action_t  tx_action;
		logic [31:0] local_seq;
		logic [31:0] ack;
		conn_state_t conn_state;
	} result_t;

	// Configuration write request.
	typedef struct packed {
		logic        we;
		cfg_index_t  index;
		logic [31:0] data;
	} cfg_wr_t;

endpackage

@@ rtl/core/trsm_front.sv @@
// Front stage: accepts segment words, classifies the flags and forms the sequence sums.
module trsm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [trsm_pkg::IN_W-1:0]     s_tdata,
	output logic                          dec_valid,
	input  logic                          dec_ready,
	output trsm_pkg::seg_dec_t            dec
);

	logic               valid_s1;
	trsm_pkg::seg_dec_t dec_s1;
	trsm_pkg::seg_dec_t dec_c;
	logic [7:0]         flags;
	logic [15:0]        len;

	assign flags = s_tdata[7:0];
	assign len   = s_tdata[55:40];

	// Exact flag matches, the RST and FIN bit tests and the two candidate ack numbers.
	always_comb begin
		dec_c.f_syn    = (flags == trsm_pkg::FLAG_SYN);
		dec_c.f_synack = (flags == (trsm_pkg::FLAG_SYN | trsm_pkg::FLAG_ACK));
		dec_c.f_finack = (flags == (trsm_pkg::FLAG_FIN | trsm_pkg::FLAG_ACK));
		dec_c.f_rstack = (flags == (trsm_pkg::FLAG_RST | trsm_pkg::FLAG_ACK));
		dec_c.f_ack    = (flags == trsm_pkg::FLAG_ACK);
		dec_c.f_fin    = (flags == trsm_pkg::FLAG_FIN);
		dec_c.rst_bit  = |(flags & trsm_pkg::FLAG_RST);
		dec_c.fin_bit  = |(flags & trsm_pkg::FLAG_FIN);
		dec_c.len_nz   = (len != 16'd0);
		dec_c.accepted = s_tdata[56];
		dec_c.owner    = s_tdata[57];
		dec_c.dack     = s_tdata[58] ? trsm_pkg::TX_DACK : trsm_pkg::TX_ACK;
		dec_c.seq      = s_tdata[39:8];
		dec_c.seq_len  = s_tdata[39:8] + {16'd0, len};
		dec_c.seq_len1 = s_tdata[39:8] + {16'd0, len} + 32'd1;
	end

	// The stage frees up whenever its word moves on to the queue.
	assign s_tready  = !valid_s1 || dec_ready;
	assign dec_valid = valid_s1;
	assign dec       = dec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			dec_s1 <= dec_c;
		end
	end

endmodule

@@ rtl/core/trsm_queue.sv @@
// Short queue of classified segments between front and back.
module trsm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  trsm_pkg::seg_dec_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output trsm_pkg::seg_dec_t pop_data
);

	trsm_pkg::seg_dec_t           mem_q [trsm_pkg::QDEPTH];
	logic [trsm_pkg::QAW-1:0]     wr_ptr_q;
	logic [trsm_pkg::QAW-1:0]     rd_ptr_q;
	logic [trsm_pkg::QAW:0]       count_q;
	logic                         push;
	logic                         pop;

	assign push_ready = (count_q != (trsm_pkg::QAW+1)'(trsm_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/trsm_back.sv @@
// Back stage: connection state, configuration registers and the result register.
module trsm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  trsm_pkg::cfg_wr_t          cfg,
	input  logic                       seg_valid,
	output logic                       seg_ready,
	input  trsm_pkg::seg_dec_t         seg,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [trsm_pkg::OUT_W-1:0] m_tdata
);

	// Configuration.
	logic        open_dir_q;
	logic [3:0]  max_dup_q;
	logic [31:0] listen_isn_q;

	// Connection state.
	trsm_pkg::conn_state_t state_q, state_d;
	logic [31:0]           ack_q, ack_d;
	logic [31:0]           lseq_q, lseq_d;
	logic [3:0]            dup_q, dup_d;
	trsm_pkg::err_code_t   err_q, err_d;
	logic                  conn_q, conn_d;
	logic                  setup_q, setup_d;

	// Per-segment outputs.
	trsm_pkg::tx_action_t  tx_c;
	logic                  deliver_c;
	logic                  release_c;

	logic                  out_valid_q;
	trsm_pkg::result_t     out_q;
	logic                  exec;
	logic                  in_order;
	logic                  start_load;

	assign seg_ready  = !out_valid_q || m_tready;
	assign exec       = seg_valid && seg_ready;
	assign in_order   = (seg.seq == ack_q);
	assign start_load = cfg.we && (cfg.index == trsm_pkg::CFG_START_STATE) &&
	                    (cfg.data[1:0] != 2'd3);

	// Next connection state and sequence bookkeeping.
	always_comb begin
		state_d = state_q;
		ack_d   = ack_q;
		lseq_d  = lseq_q;
		dup_d   = dup_q;
		err_d   = err_q;
		conn_d  = conn_q;
		setup_d = setup_q;
		unique case (state_q)
			trsm_pkg::ST_TIMEWAIT, trsm_pkg::ST_CLOSEWAIT: begin
				state_d = trsm_pkg::ST_CLOSED;
			end
			trsm_pkg::ST_LISTEN: begin
				if (seg.f_syn) begin
					lseq_d  = listen_isn_q;
					ack_d   = seg.seq_len1;
					state_d = trsm_pkg::ST_SYNRCVD;
				end
			end
			trsm_pkg::ST_SYNSENT: begin
				setup_d = 1'b1;
				state_d = trsm_pkg::ST_CLOSED;
				priority if (seg.f_syn) begin
					ack_d   = seg.seq_len1;
					state_d = trsm_pkg::ST_SYNRCVD;
					setup_d = setup_q;
				end else if (seg.f_synack) begin
					ack_d   = seg.seq_len1;
					state_d = trsm_pkg::ST_ESTAB;
					conn_d  = 1'b1;
				end else if (seg.f_finack) begin
					ack_d = seg.seq_len1;
					err_d = trsm_pkg::ERR_FIN;
				end else if (seg.f_rstack) begin
					err_d = trsm_pkg::ERR_RST;
				end else begin
					err_d = trsm_pkg::ERR_UNEXP;
				end
			end
			trsm_pkg::ST_SYNRCVD: begin
				if (seg.f_ack) begin
					ack_d = seg.seq_len;
					if (open_dir_q || seg.owner) begin
						state_d = trsm_pkg::ST_ESTAB;
						setup_d = 1'b1;
						conn_d  = open_dir_q ? 1'b1 : conn_q;
					end else begin
						state_d = trsm_pkg::ST_CLOSED;
					end
				end else if (!seg.f_syn) begin
					state_d = trsm_pkg::ST_CLOSED;
				end
			end
			trsm_pkg::ST_LASTACK: begin
				state_d = trsm_pkg::ST_CLOSED;
				if (seg.f_ack) begin
					ack_d = seg.seq_len;
				end
			end
			trsm_pkg::ST_FINWAIT1: begin
				priority if (seg.f_ack) begin
					ack_d   = seg.seq_len;
					state_d = trsm_pkg::ST_FINWAIT2;
				end else if (seg.f_fin) begin
					ack_d   = seg.seq_len1;
					state_d = trsm_pkg::ST_CLOSING;
				end else if (seg.f_finack) begin
					ack_d   = seg.seq_len1;
					state_d = trsm_pkg::ST_TIMEWAIT;
				end else begin
					state_d = trsm_pkg::ST_CLOSED;
				end
			end
			trsm_pkg::ST_FINWAIT2: begin
				if (seg.f_fin) begin
					ack_d   = seg.seq_len1;
					state_d = trsm_pkg::ST_TIMEWAIT;
				end else begin
					state_d = trsm_pkg::ST_CLOSED;
				end
			end
			trsm_pkg::ST_CLOSING: begin
				if (seg.f_ack) begin
					ack_d   = seg.seq_len;
					state_d = trsm_pkg::ST_TIMEWAIT;
				end else begin
					state_d = trsm_pkg::ST_CLOSED;
				end
			end
			trsm_pkg::ST_ESTAB: begin
				priority if (seg.rst_bit) begin
					state_d = trsm_pkg::ST_CLOSED;
				end else if (!in_order) begin
					if (dup_q < max_dup_q) begin
						dup_d = dup_q + 4'd1;
					end
				end else begin
					dup_d = 4'd0;
					if (seg.fin_bit) begin
						ack_d   = seg.seq_len1;
						state_d = trsm_pkg::ST_CLOSEWAIT;
						conn_d  = 1'b0;
					end else if (seg.len_nz && seg.accepted) begin
						ack_d = seg.seq_len;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Transmit action, payload delivery and hand-over for this segment.
	always_comb begin
		tx_c      = trsm_pkg::TX_NONE;
		deliver_c = 1'b0;
		release_c = 1'b0;
		unique case (state_q)
			trsm_pkg::ST_TIMEWAIT, trsm_pkg::ST_CLOSEWAIT: begin
				tx_c = trsm_pkg::TX_RST;
			end
			trsm_pkg::ST_LISTEN: begin
				if (seg.f_syn) begin
					tx_c = trsm_pkg::TX_SYNACK;
				end
			end
			trsm_pkg::ST_SYNSENT: begin
				priority if (seg.f_syn) begin
					tx_c = trsm_pkg::TX_SYNACK;
				end else if (seg.f_synack) begin
					tx_c = trsm_pkg::TX_ACK;
				end else if (seg.f_finack) begin
					tx_c = seg.dack;
				end else if (seg.f_rstack) begin
					tx_c = trsm_pkg::TX_NONE;
				end else begin
					tx_c = trsm_pkg::TX_RST;
				end
			end
			trsm_pkg::ST_SYNRCVD: begin
				if (seg.f_ack) begin
					if (!open_dir_q && !seg.owner) begin
						tx_c = trsm_pkg::TX_RST;
					end
					release_c = !open_dir_q && seg.owner;
				end else if (!seg.f_syn) begin
					tx_c = trsm_pkg::TX_RST;
				end
			end
			trsm_pkg::ST_LASTACK, trsm_pkg::ST_CLOSING: begin
				if (!seg.f_ack) begin
					tx_c = trsm_pkg::TX_RST;
				end
			end
			trsm_pkg::ST_FINWAIT1: begin
				if (seg.f_fin || seg.f_finack) begin
					tx_c = trsm_pkg::TX_ACK;
				end else if (!seg.f_ack) begin
					tx_c = trsm_pkg::TX_RST;
				end
			end
			trsm_pkg::ST_FINWAIT2: begin
				priority if (seg.f_fin) begin
					tx_c = trsm_pkg::TX_ACK;
				end else if (!seg.f_rstack) begin
					tx_c = trsm_pkg::TX_RST;
				end else begin
					tx_c = trsm_pkg::TX_NONE;
				end
			end
			trsm_pkg::ST_ESTAB: begin
				priority if (seg.rst_bit) begin
					tx_c = trsm_pkg::TX_NONE;
				end else if (!in_order) begin
					if (dup_q < max_dup_q) begin
						tx_c = trsm_pkg::TX_ACK;
					end
				end else if (seg.fin_bit) begin
					deliver_c = seg.len_nz;
					tx_c      = seg.dack;
				end else if (seg.len_nz) begin
					deliver_c = 1'b1;
					if (seg.accepted) begin
						tx_c = seg.dack;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The user must write configuration only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_dir_q   <= 1'b0;
			max_dup_q    <= trsm_pkg::MAX_DUP_ACKS_RST;
			listen_isn_q <= trsm_pkg::LISTEN_ISN_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				trsm_pkg::CFG_START_STATE: begin
				end
				trsm_pkg::CFG_OPEN_DIRECTION: open_dir_q   <= cfg.data[0];
				trsm_pkg::CFG_MAX_DUP_ACKS:   max_dup_q    <= cfg.data[3:0];
				trsm_pkg::CFG_LISTEN_ISN:     listen_isn_q <= cfg.data;
			endcase
		end
	end

	// Connection state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trsm_pkg::ST_CLOSED;
			ack_q   <= '0;
			lseq_q  <= '0;
			dup_q   <= '0;
			err_q   <= trsm_pkg::ERR_NONE;
			conn_q  <= 1'b0;
			setup_q <= 1'b0;
		end else if (start_load) begin
			state_q <= trsm_pkg::conn_state_t'({2'b00, cfg.data[1:0]});
			dup_q   <= '0;
			err_q   <= trsm_pkg::ERR_NONE;
			conn_q  <= 1'b0;
			setup_q <= 1'b0;
		end else if (exec) begin
			state_q <= state_d;
			ack_q   <= ack_d;
			lseq_q  <= lseq_d;
			dup_q   <= dup_d;
			err_q   <= err_d;
			conn_q  <= conn_d;
			setup_q <= setup_d;
		end
	end

	// Result register toward the master side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seg_ready) begin
			out_valid_q <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_q.conn_state    <= state_d;
			out_q.ack           <= ack_d;
			out_q.local_seq     <= lseq_d;
			out_q.tx_action     <= tx_c;
			out_q.deliver       <= deliver_c;
			out_q.error_code    <= err_d;
			out_q.connected     <= conn_d;
			out_q.setup_done    <= setup_d;
			out_q.release_owner <= release_c;
			out_q.dup_count     <= dup_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

@@ rtl/core/tcp_receive_state_machine_top.sv @@
// Top level of the TCP receive state machine for one connection slot.
//
// Received segment headers enter on the s_ group, one word per segment, and
// each produces exactly one result word on the m_ group. A word is taken at a
// rising edge where tvalid and tready are both high.
// The front stage registers and classifies a segment, a four-entry queue
// buffers it, and the back stage updates the connection state and loads the
// result register. One segment per cycle is sustained while m_tready stays
// high; the rate is set by the combinational state update in the back stage
// (one 32-bit compare and a select).
// When the receiver holds m_tready low the result register holds, the queue
// fills, and s_tready falls once the front stage can no longer move on.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// segment is in flight; a start_state code of 0 to 2 reloads the connection state.
// Reset clears the connection state and the queue and loads the register
// defaults (five duplicate ACKs, listen initial sequence 1000).
module tcp_receive_state_machine_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// seg_flags[7:0], seg_seq[39:8], payload_len[55:40], rx_accepted[56],
	// originator_present[57], want_delay_ack[58], zero fill
	input  logic [trsm_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// conn_state_out[3:0], ack_out[35:4], local_seq_out[67:36],
	// tx_action[70:68], deliver_payload[71], error_code[73:72],
	// connected_out[74], setup_done[75], release_to_owner[76],
	// dup_count_out[80:77], zero fill
	output logic [trsm_pkg::OUT_W-1:0] m_tdata,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);

	logic               dec_valid;
	logic               dec_ready;
	trsm_pkg::seg_dec_t dec;
	logic               seg_valid;
	logic               seg_ready;
	trsm_pkg::seg_dec_t seg;
	trsm_pkg::cfg_wr_t  cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = trsm_pkg::cfg_index_t'(cfg_index);
	assign cfg.data  = cfg_data;

	trsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec       (dec)
	);

	trsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (dec_valid),
		.push_ready (dec_ready),
		.push_data  (dec),
		.pop_valid  (seg_valid),
		.pop_ready  (seg_ready),
		.pop_data   (seg)
	);

	trsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg       (seg),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

@@ tb/tb_tcp_receive_state_machine_top.sv @@
// Self-checking testbench of the TCP receive state machine: directed table, then random phases.
module tb_tcp_receive_state_machine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import trsm_pkg::*;

	localparam int DIR_ROWS    = 39;
	localparam int BUSY_TARGET = 1850;

	// Push flag, used to build unexpected flag bytes and data segments.
	localparam logic [7:0] FLAG_PSH = 8'h08;

	// One segment header as it is packed into s_tdata, last field lowest.
	typedef struct packed {
		logic        want_dack;
		logic        owner;
		logic        accepted;
		logic [15:0] len;
		logic [31:0] seq;
		logic [7:0]  flags;
	} seg_t;

	// One row of the directed table: a register write or a segment.
	typedef struct packed {
		logic        is_cfg;
		cfg_index_t  idx;
		logic [31:0] cdata;
		seg_t        seg;
		logic        fixed;
		result_t     res;
	} step_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [31:0]         cfg_data;

	// Shadow copy of the connection slot and its registers.
	conn_state_t conn_st;
	logic [31:0] ack_num;
	logic [31:0] loc_seq;
	logic [3:0]  dup_cnt;
	err_code_t   err_st;
	logic        conn_flag;
	logic        setup_flag;
	logic        cfg_outgoing;
	logic [3:0]  cfg_dup_max;
	logic [31:0] cfg_isn;

	result_t     expected_words[$];
	int          fail_count;
	bit          no_idle;
	step_row_t   dir_tab [DIR_ROWS];

	tcp_receive_state_machine_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Advance the shadow slot by one segment and return the word it should produce.
	function automatic result_t predict_segment(seg_t s);
		logic [31:0] sl;
		logic [31:0] sl1;
		tx_action_t  tx;
		tx_action_t  dk;
		logic        dlv;
		logic        rel;
		result_t     r;
		sl  = s.seq + {16'h0000, s.len};
		sl1 = sl + 32'd1;
		dk  = s.want_dack ? TX_DACK : TX_ACK;
		tx  = TX_NONE;
		dlv = 1'b0;
		rel = 1'b0;
		case (conn_st)
			ST_TIMEWAIT, ST_CLOSEWAIT: begin
				tx = TX_RST;
				conn_st = ST_CLOSED;
			end
			ST_LISTEN: begin
				if (s.flags == FLAG_SYN) begin
					loc_seq = cfg_isn;
					ack_num = sl1;
					tx = TX_SYNACK;
					conn_st = ST_SYNRCVD;
				end
			end
			ST_SYNSENT: begin
				// A plain SYN is a simultaneous open; every other segment ends the connect.
				if (s.flags == FLAG_SYN) begin
					ack_num = sl1;
					tx = TX_SYNACK;
					conn_st = ST_SYNRCVD;
				end else if (s.flags == (FLAG_ACK | FLAG_SYN)) begin
					ack_num = sl1;
					tx = TX_ACK;
					conn_st = ST_ESTAB;
					setup_flag = 1'b1;
					conn_flag = 1'b1;
				end else if (s.flags == (FLAG_ACK | FLAG_FIN)) begin
					ack_num = sl1;
					tx = dk;
					conn_st = ST_CLOSED;
					err_st = ERR_FIN;
					setup_flag = 1'b1;
				end else if (s.flags == (FLAG_ACK | FLAG_RST)) begin
					conn_st = ST_CLOSED;
					err_st = ERR_RST;
					setup_flag = 1'b1;
				end else begin
					tx = TX_RST;
					conn_st = ST_CLOSED;
					err_st = ERR_UNEXP;
					setup_flag = 1'b1;
				end
			end
			ST_SYNRCVD: begin
				if (s.flags == FLAG_ACK) begin
					ack_num = sl;
					if (!cfg_outgoing) begin
						if (!s.owner) begin
							tx = TX_RST;
							conn_st = ST_CLOSED;
						end else begin
							conn_st = ST_ESTAB;
							setup_flag = 1'b1;
							rel = 1'b1;
						end
					end else begin
						conn_st = ST_ESTAB;
						setup_flag = 1'b1;
						conn_flag = 1'b1;
					end
				end else if (s.flags != FLAG_SYN) begin
					tx = TX_RST;
					conn_st = ST_CLOSED;
				end
			end
			ST_LASTACK: begin
				if (s.flags == FLAG_ACK) begin
					ack_num = sl;
				end else begin
					tx = TX_RST;
				end
				conn_st = ST_CLOSED;
			end
			ST_FINWAIT1: begin
				if (s.flags == FLAG_ACK) begin
					ack_num = sl;
					conn_st = ST_FINWAIT2;
				end else if (s.flags == FLAG_FIN) begin
					ack_num = sl1;
					conn_st = ST_CLOSING;
					tx = TX_ACK;
				end else if (s.flags == (FLAG_FIN | FLAG_ACK)) begin
					ack_num = sl1;
					conn_st = ST_TIMEWAIT;
					tx = TX_ACK;
				end else begin
					tx = TX_RST;
					conn_st = ST_CLOSED;
				end
			end
			ST_FINWAIT2: begin
				if (s.flags == FLAG_FIN) begin
					ack_num = sl1;
					conn_st = ST_TIMEWAIT;
					tx = TX_ACK;
				end else if (s.flags == (FLAG_ACK | FLAG_RST)) begin
					conn_st = ST_CLOSED;
				end else begin
					tx = TX_RST;
					conn_st = ST_CLOSED;
				end
			end
			ST_CLOSING: begin
				if (s.flags == FLAG_ACK) begin
					ack_num = sl;
					conn_st = ST_TIMEWAIT;
				end else begin
					tx = TX_RST;
					conn_st = ST_CLOSED;
				end
			end
			ST_ESTAB: begin
				if ((s.flags & FLAG_RST) != 8'h00) begin
					conn_st = ST_CLOSED;
				end else if (s.seq != ack_num) begin
					// Out-of-order data earns a duplicate ACK until the cap is reached.
					if (dup_cnt < cfg_dup_max) begin
						dup_cnt = dup_cnt + 4'd1;
						tx = TX_ACK;
					end
				end else begin
					dup_cnt = 4'd0;
					if ((s.flags & FLAG_FIN) != 8'h00) begin
						dlv = (s.len != 16'h0000);
						ack_num = sl1;
						tx = dk;
						conn_st = ST_CLOSEWAIT;
						conn_flag = 1'b0;
					end else if (s.len != 16'h0000) begin
						dlv = 1'b1;
						if (s.accepted) begin
							ack_num = sl;
							tx = dk;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.conn_state    = conn_st;
		r.ack           = ack_num;
		r.local_seq     = loc_seq;
		r.tx_action     = tx;
		r.deliver       = dlv;
		r.error_code    = err_st;
		r.connected     = conn_flag;
		r.setup_done    = setup_flag;
		r.release_owner = rel;
		r.dup_count     = dup_cnt;
		return r;
	endfunction

	// A closed-state word with nothing but an action, an error and the setup flag.
	function automatic result_t closed_word(tx_action_t tx, err_code_t err, logic setup);
		result_t r;
		r = '0;
		r.conn_state = ST_CLOSED;
		r.tx_action  = tx;
		r.error_code = err;
		r.setup_done = setup;
		return r;
	endfunction

	function automatic step_row_t cfg_row(cfg_index_t idx, logic [31:0] data);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.cdata  = data;
		return r;
	endfunction

	function automatic step_row_t seg_row(logic [7:0] flags, logic [31:0] seq, logic [15:0] len,
			logic acc, logic own, logic dk);
		step_row_t r;
		r = '0;
		r.seg.flags     = flags;
		r.seg.seq       = seq;
		r.seg.len       = len;
		r.seg.accepted  = acc;
		r.seg.owner     = own;
		r.seg.want_dack = dk;
		return r;
	endfunction

	function automatic step_row_t fix_row(step_row_t r, result_t w);
		step_row_t o;
		o = r;
		o.fixed = 1'b1;
		o.res   = w;
		return o;
	endfunction

	// Payload length: mostly short, with the extremes and full-range values mixed in.
	function automatic logic [15:0] rand_len();
		logic [15:0] l;
		case ($urandom_range(0, 9))
			0: l = 16'h0000;
			1: l = 16'hFFFF;
			2, 3: l = 16'($urandom);
			default: l = 16'($urandom_range(1, 64));
		endcase
		return l;
	endfunction

	// Build the next random segment, steered by the shadow state so that sessions go deep.
	function automatic seg_t next_segment();
		seg_t s;
		int   pick;
		int   sub;
		s.flags     = 8'($urandom_range(0, 255));
		s.seq       = $urandom;
		s.len       = rand_len();
		s.accepted  = 1'($urandom_range(0, 1));
		s.owner     = ($urandom_range(0, 3) != 0);
		s.want_dack = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		sub  = $urandom_range(0, 9);
		case (conn_st)
			ST_LISTEN: begin
				if (pick < 75) s.flags = FLAG_SYN;
			end
			ST_SYNSENT: begin
				if (pick < 35) s.flags = FLAG_ACK | FLAG_SYN;
				else if (pick < 55) s.flags = FLAG_SYN;
				else if (pick < 70) s.flags = FLAG_ACK | FLAG_FIN;
				else if (pick < 80) s.flags = FLAG_ACK | FLAG_RST;
			end
			ST_SYNRCVD: begin
				if (pick < 65) s.flags = FLAG_ACK;
				else if (pick < 80) s.flags = FLAG_SYN;
			end
			ST_ESTAB: begin
				if (pick < 6) begin
					s.flags = s.flags | FLAG_RST;
				end else if (pick < 30) begin
					s.flags = s.flags & ~FLAG_RST;
					if (sub < 3) s.seq = ack_num + 32'd1;
				end else begin
					s.seq = ack_num;
					if (sub == 0) s.flags = FLAG_ACK | FLAG_FIN;
					else if (sub == 1) s.flags = s.flags & ~FLAG_RST;
					else if (sub < 6) s.flags = FLAG_ACK;
					else s.flags = FLAG_PSH | FLAG_ACK;
				end
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	// Write one register and mirror it into the shadow copy.
	task automatic cfg_write(cfg_index_t idx, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_START_STATE: begin
				// The unused start code leaves the slot as it is.
				if (data[1:0] <= 2'(ST_SYNSENT)) begin
					conn_st    = conn_state_t'({2'b00, data[1:0]});
					dup_cnt    = 4'd0;
					err_st     = ERR_NONE;
					conn_flag  = 1'b0;
					setup_flag = 1'b0;
				end
			end
			CFG_OPEN_DIRECTION: cfg_outgoing = data[0];
			CFG_MAX_DUP_ACKS:   cfg_dup_max  = data[3:0];
			default:            cfg_isn      = data;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one segment word after a random gap and record what it should produce.
	task automatic send_seg(seg_t s, logic fixed, result_t fix_res);
		int      gap;
		result_t w;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(s);
		do @(posedge clk); while (!s_tready);
		w = predict_segment(s);
		expected_words.push_back(fixed ? fix_res : w);
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected word has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Receiver: random stalls between words, each word checked against the oldest expectation.
	initial begin
		int      stall;
		result_t got;
		result_t want;
		m_tready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= (stall == 0);
			if (stall > 0) stall--;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(result_t)-1:0];
				if (expected_words.size() == 0) begin
					$display("%0t: result word with no expectation, actual %h", $time, got);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("conn_state_out", want.conn_state, got.conn_state);
					check_field("ack_out", want.ack, got.ack);
					check_field("local_seq_out", want.local_seq, got.local_seq);
					check_field("tx_action", want.tx_action, got.tx_action);
					check_field("deliver_payload", want.deliver, got.deliver);
					check_field("error_code", want.error_code, got.error_code);
					check_field("connected_out", want.connected, got.connected);
					check_field("setup_done", want.setup_done, got.setup_done);
					check_field("release_to_owner", want.release_owner, got.release_owner);
					check_field("dup_count_out", want.dup_count, got.dup_count);
				end
				stall = no_idle ? 0 : $urandom_range(0, 8);
			end
		end
	end

	// Run limit far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Stimulus: reset, the directed table, then random phases.
	initial begin
		int          busy;
		int          n_items;
		int          sent;
		int          pick;
		logic [31:0] v;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_START_STATE;
		cfg_data   = '0;
		fail_count = 0;
		no_idle    = 1'b0;
		conn_st    = ST_CLOSED;
		ack_num    = '0;
		loc_seq    = '0;
		dup_cnt    = '0;
		err_st     = ERR_NONE;
		conn_flag  = 1'b0;
		setup_flag = 1'b0;
		cfg_outgoing = 1'b0;
		cfg_dup_max  = MAX_DUP_ACKS_RST;
		cfg_isn      = LISTEN_ISN_RST;
		busy = 0;

		dir_tab = '{
			// Closed after reset ignores even an all-ones word.
			fix_row(seg_row(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1),
				closed_word(TX_NONE, ERR_NONE, 1'b0)),
			// Connect errors out of syn sent: unexpected flags, RST, FIN with wrap.
			cfg_row(CFG_START_STATE, 32'd2),
			fix_row(seg_row(FLAG_PSH, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0),
				closed_word(TX_RST, ERR_UNEXP, 1'b1)),
			cfg_row(CFG_START_STATE, 32'd2),
			fix_row(seg_row(FLAG_RST | FLAG_ACK, 32'd5, 16'h0, 1'b0, 1'b0, 1'b0),
				closed_word(TX_NONE, ERR_RST, 1'b1)),
			cfg_row(CFG_START_STATE, 32'd2),
			fix_row(seg_row(FLAG_FIN | FLAG_ACK, 32'hFFFF_FFFF, 16'h0, 1'b0, 1'b0, 1'b1),
				closed_word(TX_DACK, ERR_FIN, 1'b1)),
			// Outgoing open, data in order, data not taken, out of order, close.
			cfg_row(CFG_START_STATE, 32'd2),
			seg_row(FLAG_SYN | FLAG_ACK, 32'd100, 16'h0, 1'b0, 1'b0, 1'b0),
			seg_row(FLAG_PSH | FLAG_ACK, 32'd101, 16'd10, 1'b1, 1'b0, 1'b0),
			seg_row(FLAG_ACK, 32'd111, 16'd5, 1'b0, 1'b0, 1'b1),
			seg_row(FLAG_ACK, 32'd0, 16'h0, 1'b1, 1'b1, 1'b0),
			cfg_row(CFG_START_STATE, 32'hFFFF_FFFF),
			seg_row(FLAG_ACK, 32'd111, 16'h0, 1'b0, 1'b0, 1'b0),
			seg_row(FLAG_FIN | FLAG_ACK, 32'd111, 16'd3, 1'b0, 1'b0, 1'b1),
			seg_row(FLAG_ACK, 32'd7, 16'h0, 1'b0, 1'b0, 1'b0),
			// Listen slot with the largest initial sequence, owner gone.
			cfg_row(CFG_LISTEN_ISN, 32'hFFFF_FFFF),
			cfg_row(CFG_OPEN_DIRECTION, 32'd0),
			cfg_row(CFG_START_STATE, 32'd1),
			seg_row(FLAG_ACK, 32'd1, 16'h0, 1'b0, 1'b1, 1'b0),
			seg_row(FLAG_SYN, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0),
			seg_row(FLAG_SYN, 32'd3, 16'h0, 1'b0, 1'b1, 1'b0),
			seg_row(FLAG_ACK, 32'hFFFF, 16'h0, 1'b0, 1'b0, 1'b0),
			// Listen slot handed to its owner, then reset by RST.
			cfg_row(CFG_START_STATE, 32'd1),
			seg_row(FLAG_SYN, 32'd7, 16'h0, 1'b0, 1'b1, 1'b0),
			seg_row(FLAG_ACK, 32'd8, 16'h0, 1'b0, 1'b1, 1'b0),
			seg_row(FLAG_RST | FLAG_PSH, 32'd8, 16'd4, 1'b1, 1'b1, 1'b0),
			// Simultaneous open with no duplicate ACKs allowed.
			cfg_row(CFG_MAX_DUP_ACKS, 32'd0),
			cfg_row(CFG_OPEN_DIRECTION, 32'd1),
			cfg_row(CFG_LISTEN_ISN, 32'd0),
			cfg_row(CFG_START_STATE, 32'd2),
			seg_row(FLAG_SYN, 32'd50, 16'h0, 1'b0, 1'b0, 1'b0),
			seg_row(FLAG_ACK, 32'd51, 16'h0, 1'b0, 1'b0, 1'b0),
			seg_row(FLAG_ACK, 32'd9, 16'h0, 1'b0, 1'b0, 1'b0),
			seg_row(FLAG_ACK, 32'd51, 16'hFFFF, 1'b1, 1'b0, 1'b1),
			// Bad flags in syn received.
			cfg_row(CFG_MAX_DUP_ACKS, 32'd15),
			cfg_row(CFG_START_STATE, 32'd2),
			seg_row(FLAG_SYN, 32'd0, 16'h0, 1'b0, 1'b0, 1'b0),
			seg_row(8'h1A, 32'd1, 16'h0, 1'b0, 1'b0, 1'b0)
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].is_cfg) begin
				drain();
				cfg_write(dir_tab[i].idx, dir_tab[i].cdata);
			end else begin
				send_seg(dir_tab[i].seg, dir_tab[i].fixed, dir_tab[i].res);
			end
		end

		// Random phases: new settings while idle, then one session of segments.
		while (busy < BUSY_TARGET) begin
			drain();
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, 3);
				v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd15 : 32'($urandom_range(0, 15));
				if ($urandom_range(0, 1) == 1) v = ($urandom & ~32'hF) | v;
				cfg_write(CFG_MAX_DUP_ACKS, v);
			end
			if ($urandom_range(0, 1) == 1) begin
				v = 32'($urandom_range(0, 1));
				if ($urandom_range(0, 1) == 1) v = ($urandom & ~32'h1) | v;
				cfg_write(CFG_OPEN_DIRECTION, v);
			end
			if ($urandom_range(0, 2) == 0) begin
				pick = $urandom_range(0, 3);
				v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
				cfg_write(CFG_LISTEN_ISN, v);
			end
			pick = $urandom_range(0, 99);
			v = (pick < 40) ? 32'd1 : (pick < 85) ? 32'd2 : (pick < 90) ? 32'd0 : 32'd3;
			if ($urandom_range(0, 1) == 1) v = ($urandom & ~32'h3) | v;
			cfg_write(CFG_START_STATE, v);

			n_items = $urandom_range(5, 40);
			sent = 0;
			while (sent < n_items) begin
				if (conn_st == ST_CLOSED) begin
					// A closed slot only ignores words; end the session here.
					if ($urandom_range(0, 2) == 0) send_seg(next_segment(), 1'b0, '0);
					break;
				end
				send_seg(next_segment(), 1'b0, '0);
				sent++;
				busy++;
				// Now and then hold the sender until the pipeline is empty.
				if ($urandom_range(0, 49) == 0) drain();
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
